/* sv/sacl_pkg.sv */
package sacl_pkg;

  localparam int SET_COUNT  = 256;
  localparam int WAY_COUNT  = 4;
  localparam int LINE_BYTES = 64;

  localparam int ADDR_W = 48;
  localparam int CNT_W  = 32;
  localparam int LFSR_W = 16;

  // Floor of log2 for the offset and set index fields.
  localparam int OFS_BITS  = $clog2(LINE_BYTES + 1) - 1;
  localparam int IDX_BITS  = $clog2(SET_COUNT + 1) - 1;
  localparam int SET_AW    = (IDX_BITS > 0) ? IDX_BITS : 1;
  localparam int SET_DEPTH = 1 << IDX_BITS;
  localparam int TAG_SHIFT = OFS_BITS + IDX_BITS;
  localparam int TAG_W     = ADDR_W - TAG_SHIFT;
  localparam int WAY_W     = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int MOD_W     = WAY_W + 2;

  localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((64'd1 << IDX_BITS) - 64'd1);

  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam int LFSR_MOD_K    = (1 << LFSR_W) % WAY_COUNT;
  localparam int SEED_MOD      = 16'hACE1 % WAY_COUNT;
  localparam logic [MOD_W-1:0] LFSR_SEED_MOD = MOD_W'(SEED_MOD);
  localparam logic [MOD_W-1:0] WAY_M         = MOD_W'(WAY_COUNT);
  localparam logic [MOD_W-1:0] LFSR_ADD      = MOD_W'(WAY_COUNT - LFSR_MOD_K);
  localparam logic [WAY_W-1:0] OLDEST_AGE    = WAY_W'(WAY_COUNT - 1);

  typedef logic [WAY_W-1:0]  way_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [SET_AW-1:0] set_t;

  typedef struct packed {
    logic [WAY_COUNT-1:0]            valid;
    logic [WAY_COUNT-1:0]            dirty;
    logic [WAY_COUNT-1:0][WAY_W-1:0] age;
    logic [WAY_COUNT-1:0][TAG_W-1:0] tag;
  } row_t;

  typedef struct packed {
    logic hit;
    logic victim_dirty;
    logic rand_used;
    tag_t victim_tag;
  } lookup_t;

  function automatic row_t reset_row();
    row_t r;
    r = '0;
    for (int w = 0; w < WAY_COUNT; w++) begin
      r.age[w] = WAY_W'(w);
    end
    return r;
  endfunction

  function automatic set_t set_of(logic [ADDR_W-1:0] addr);
    return SET_AW'((addr >> OFS_BITS) & SET_MASK);
  endfunction

  function automatic tag_t tag_of(logic [ADDR_W-1:0] addr);
    return TAG_W'(addr >> TAG_SHIFT);
  endfunction

  function automatic logic [LFSR_W-1:0] lfsr_step(logic [LFSR_W-1:0] s);
    logic fb;
    fb = s[15] ^ s[13] ^ s[12] ^ s[10];
    return {s[14:0], fb};
  endfunction

  // Remainder of the next LFSR value by the way count, from the current
  // remainder: shifting left doubles it, and the bit shifted out removes 2^16.
  function automatic logic [MOD_W-1:0] lfsr_mod_step(logic [MOD_W-1:0] m,
                                                     logic [LFSR_W-1:0] s);
    logic       fb;
    logic [MOD_W-1:0] t;
    fb = s[15] ^ s[13] ^ s[12] ^ s[10];
    t = (m << 1) + MOD_W'(fb) + (s[15] ? LFSR_ADD : '0);
    if (t >= WAY_M) t = t - WAY_M;
    if (t >= WAY_M) t = t - WAY_M;
    return t;
  endfunction

endpackage

/* sv/sacl_store.sv */
module sacl_store
  import sacl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  set_t rd_set,
  output row_t rd_row,
  input  logic wr_en,
  input  set_t wr_set,
  input  row_t wr_row
);

  row_t mem_r [SET_DEPTH];
  row_t rd_data_r;
  row_t byp_row_r;
  logic byp_r;
  logic [SET_DEPTH-1:0] init_r;
  logic init_q_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_set] <= wr_row;
    end
    rd_data_r <= mem_r[rd_set];
    byp_row_r <= wr_row;
  end

  // A set that was never written reads as its reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r   <= '0;
      init_q_r <= 1'b0;
      byp_r    <= 1'b0;
    end else begin
      if (wr_en) begin
        init_r[wr_set] <= 1'b1;
      end
      init_q_r <= init_r[rd_set];
      byp_r    <= wr_en && (wr_set == rd_set);
    end
  end

  always_comb begin
    if (byp_r) begin
      rd_row = byp_row_r;
    end else if (init_q_r) begin
      rd_row = rd_data_r;
    end else begin
      rd_row = reset_row();
    end
  end

endmodule

/* sv/sacl_lookup.sv */
module sacl_lookup
  import sacl_pkg::*;
(
  input  row_t    row,
  input  tag_t    tag,
  input  logic    kind,
  input  logic    policy,
  input  way_t    rnd_way,
  output lookup_t lk,
  output row_t    row_nxt
);

  logic [WAY_COUNT-1:0] hit_vec;
  logic [WAY_COUNT-1:0] old_vec;
  logic any_inv;
  way_t hit_way;
  way_t inv_way;
  way_t old_way;
  way_t victim;
  way_t tgt;
  logic [WAY_W-1:0] tgt_age;

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    old_way = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      hit_vec[w] = row.valid[w] && (row.tag[w] == tag);
      old_vec[w] = (row.age[w] == OLDEST_AGE);
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (!row.valid[w]) inv_way = WAY_W'(w);
      if (old_vec[w]) old_way = WAY_W'(w);
    end
    any_inv = ~&row.valid;

    if (any_inv) begin
      victim = inv_way;
    end else if (policy) begin
      victim = rnd_way;
    end else begin
      victim = old_way;
    end

    lk.hit          = |hit_vec;
    lk.victim_dirty = !lk.hit && row.valid[victim] && row.dirty[victim];
    lk.rand_used    = !lk.hit && !any_inv && policy;
    lk.victim_tag   = row.tag[victim];

    tgt     = lk.hit ? hit_way : victim;
    tgt_age = row.age[tgt];

    // The touched way becomes newest; every younger way ages by one.
    row_nxt = row;
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (row.age[w] < tgt_age) row_nxt.age[w] = row.age[w] + 1'b1;
    end
    row_nxt.age[tgt] = '0;
    if (lk.hit) begin
      row_nxt.dirty[tgt] = row.dirty[tgt] | kind;
    end else begin
      row_nxt.valid[tgt] = 1'b1;
      row_nxt.dirty[tgt] = kind;
      row_nxt.tag[tgt]   = tag;
    end
  end

endmodule

/* sv/set_assoc_cache_lru_writeback.sv */
// A request accepted at a clock edge is registered into the s1 stage, looked up there,
// and its result is then registered onto the out_ ports, with out_valid high.
// Throughput: one request per cycle; busy stays low, and a request to the set just
// updated is served from a bypass register around the set memory.
// Reset clears the counters, resets the configuration (oldest-way policy, lower level
// present), clears every line (through per-set flags, no clearing pass) and loads the LFSR seed.
module set_assoc_cache_lru_writeback
  import sacl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_kind,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  output logic              out_hit,
  output logic              out_writeback_valid,
  output logic [ADDR_W-1:0] out_writeback_address,
  output logic              out_fill_valid,
  output logic [ADDR_W-1:0] out_fill_address,
  output logic [CNT_W-1:0]  out_access_total,
  output logic [CNT_W-1:0]  out_miss_total,
  output logic [CNT_W-1:0]  out_writeback_total,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data
);

  localparam logic REG_POLICY      = 1'b0;
  localparam logic REG_LOWER_LEVEL = 1'b1;

  logic policy_r;
  logic next_lvl_r;
  logic s1_valid_r;
  logic s1_kind_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [LFSR_W-1:0] lfsr_r;
  logic [MOD_W-1:0]  lfsr_mod_r;
  logic [CNT_W-1:0]  acc_r;
  logic [CNT_W-1:0]  miss_r;
  logic [CNT_W-1:0]  wb_cnt_r;
  logic out_valid_r;
  logic hit_r;
  logic wbv_r;
  logic [ADDR_W-1:0] wba_r;
  logic fv_r;
  logic [ADDR_W-1:0] fa_r;

  logic accept;
  row_t rd_row;
  row_t row_nxt;
  lookup_t lk;
  set_t s1_set;
  logic [MOD_W-1:0] mod_nxt;
  logic wb_fire;
  logic [ADDR_W-1:0] wb_addr;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign s1_set = set_of(s1_addr_r);
  assign mod_nxt = lfsr_mod_step(lfsr_mod_r, lfsr_r);

  sacl_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_set (set_of(in_address)),
    .rd_row (rd_row),
    .wr_en  (s1_valid_r),
    .wr_set (s1_set),
    .wr_row (row_nxt)
  );

  sacl_lookup u_lookup (
    .row     (rd_row),
    .tag     (tag_of(s1_addr_r)),
    .kind    (s1_kind_r),
    .policy  (policy_r),
    .rnd_way (WAY_W'(mod_nxt)),
    .lk      (lk),
    .row_nxt (row_nxt)
  );

  assign wb_fire = lk.victim_dirty && next_lvl_r;
  assign wb_addr = (ADDR_W'(lk.victim_tag) << TAG_SHIFT) | (ADDR_W'(s1_set) << OFS_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= 1'b0;
      next_lvl_r  <= 1'b1;
      s1_valid_r  <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      lfsr_mod_r  <= LFSR_SEED_MOD;
      acc_r       <= '0;
      miss_r      <= '0;
      wb_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_POLICY:      policy_r   <= cfg_data;
          REG_LOWER_LEVEL: next_lvl_r <= cfg_data;
          default:         ;
        endcase
      end
      s1_valid_r  <= accept;
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        acc_r <= sat_inc(acc_r);
        if (!lk.hit) miss_r <= sat_inc(miss_r);
        if (wb_fire) wb_cnt_r <= sat_inc(wb_cnt_r);
        if (lk.rand_used) begin
          lfsr_r     <= lfsr_step(lfsr_r);
          lfsr_mod_r <= mod_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind_r <= in_kind;
      s1_addr_r <= in_address;
    end
    if (s1_valid_r) begin
      hit_r <= lk.hit;
      wbv_r <= wb_fire;
      wba_r <= wb_fire ? wb_addr : '0;
      fv_r  <= !lk.hit && next_lvl_r;
      fa_r  <= (!lk.hit && next_lvl_r) ? s1_addr_r : '0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_hit               = hit_r;
  assign out_writeback_valid   = wbv_r;
  assign out_writeback_address = wba_r;
  assign out_fill_valid        = fv_r;
  assign out_fill_address      = fa_r;
  assign out_access_total      = acc_r;
  assign out_miss_total        = miss_r;
  assign out_writeback_total   = wb_cnt_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ##1 out_valid)
    else $error("result strobe missing two cycles after a request");

  a_fill_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_valid |-> !out_hit)
    else $error("fill requested on a hit");

  a_wb_needs_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_writeback_valid |-> out_fill_valid)
    else $error("writeback without a fill");

  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_miss_total <= out_access_total) &&
                  (out_writeback_total <= out_miss_total))
    else $error("counters out of order");

endmodule

/* tb/sacl_tb_pkg.sv */
`timescale 1ns / 1ps

package sacl_tb_pkg;

  // Configuration register indexes.
  localparam logic REG_POLICY      = 1'b0;
  localparam logic REG_LOWER_LEVEL = 1'b1;

  // Replacement policy values.
  localparam logic POLICY_OLDEST = 1'b0;
  localparam logic POLICY_RANDOM = 1'b1;

  // Access kinds.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

endpackage

/* tb/sacl_checker.sv */
`timescale 1ns / 1ps

module sacl_checker
  import sacl_pkg::*;
  import sacl_tb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic              in_kind,
  input  logic [ADDR_W-1:0] in_address,
  input  logic              out_valid,
  input  logic              out_hit,
  input  logic              out_writeback_valid,
  input  logic [ADDR_W-1:0] out_writeback_address,
  input  logic              out_fill_valid,
  input  logic [ADDR_W-1:0] out_fill_address,
  input  logic [CNT_W-1:0]  out_access_total,
  input  logic [CNT_W-1:0]  out_miss_total,
  input  logic [CNT_W-1:0]  out_writeback_total,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic              cfg_data,
  output int                mismatches,
  output int                pending
);

  typedef struct packed {
    logic              hit;
    logic              wb_valid;
    logic [ADDR_W-1:0] wb_addr;
    logic              fill_valid;
    logic [ADDR_W-1:0] fill_addr;
    logic [CNT_W-1:0]  accesses;
    logic [CNT_W-1:0]  misses;
    logic [CNT_W-1:0]  writebacks;
  } access_result_t;

  logic line_valid [SET_DEPTH][WAY_COUNT];
  logic line_dirty [SET_DEPTH][WAY_COUNT];
  tag_t line_tag   [SET_DEPTH][WAY_COUNT];
  way_t line_age   [SET_DEPTH][WAY_COUNT];

  logic              policy;
  logic              lower_present;
  logic [CNT_W-1:0]  access_cnt;
  logic [CNT_W-1:0]  miss_cnt;
  logic [CNT_W-1:0]  wb_cnt;
  logic [LFSR_W-1:0] lfsr;

  access_result_t expected_results[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Ages younger than the touched way grow by one; the touched way becomes newest.
  task automatic make_most_recent(input int s, input int way);
    way_t old_age;
    old_age = line_age[s][way];
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (line_age[s][w] < old_age) line_age[s][w] = line_age[s][w] + 1'b1;
    end
    line_age[s][way] = '0;
  endtask

  task automatic predict_access(input logic is_write, input logic [ADDR_W-1:0] addr,
                                output access_result_t r);
    int   s;
    int   victim;
    bit   found;
    tag_t tag;
    logic fb;
    s = int'((addr >> OFS_BITS) % SET_DEPTH);
    tag = TAG_W'(addr >> TAG_SHIFT);
    found = 0;
    r = '0;
    access_cnt = sat_inc(access_cnt);
    for (int w = 0; w < WAY_COUNT; w++) begin
      if (!found && line_valid[s][w] && line_tag[s][w] == tag) begin
        if (is_write) line_dirty[s][w] = 1'b1;
        make_most_recent(s, w);
        found = 1;
      end
    end
    if (!found) begin
      miss_cnt = sat_inc(miss_cnt);
      victim = WAY_COUNT;
      for (int w = WAY_COUNT - 1; w >= 0; w--) begin
        if (!line_valid[s][w]) victim = w;
      end
      if (victim == WAY_COUNT) begin
        if (policy == POLICY_OLDEST) begin
          victim = 0;
          for (int w = 1; w < WAY_COUNT; w++) begin
            if (line_age[s][w] > line_age[s][victim]) victim = w;
          end
        end else begin
          fb = lfsr[15] ^ lfsr[13] ^ lfsr[12] ^ lfsr[10];
          lfsr = {lfsr[14:0], fb};
          victim = int'(lfsr) % WAY_COUNT;
        end
      end
      if (line_valid[s][victim] && line_dirty[s][victim] && lower_present) begin
        r.wb_valid = 1'b1;
        r.wb_addr = (ADDR_W'(line_tag[s][victim]) << TAG_SHIFT) |
                    (ADDR_W'(s) << OFS_BITS);
        wb_cnt = sat_inc(wb_cnt);
      end
      if (lower_present) begin
        r.fill_valid = 1'b1;
        r.fill_addr = addr;
      end
      line_valid[s][victim] = 1'b1;
      line_dirty[s][victim] = is_write;
      line_tag[s][victim] = tag;
      make_most_recent(s, victim);
    end
    r.hit = found;
    r.accesses = access_cnt;
    r.misses = miss_cnt;
    r.writebacks = wb_cnt;
  endtask

  task automatic check_field(input string name, input logic [ADDR_W-1:0] exp_v,
                             input logic [ADDR_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    access_result_t exp_r;
    access_result_t new_r;
    if (!rst_n) begin
      for (int s = 0; s < SET_DEPTH; s++) begin
        for (int w = 0; w < WAY_COUNT; w++) begin
          line_valid[s][w] = 1'b0;
          line_dirty[s][w] = 1'b0;
          line_tag[s][w] = '0;
          line_age[s][w] = way_t'(w);
        end
      end
      policy = POLICY_OLDEST;
      lower_present = 1'b1;
      access_cnt = '0;
      miss_cnt = '0;
      wb_cnt = '0;
      lfsr = LFSR_SEED;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_POLICY) policy = cfg_data;
        else lower_present = cfg_data;
      end
      // Results are matched before this edge's request is predicted, so a request
      // can never be paired with a result strobed on the edge that accepts it.
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("result strobed with no request outstanding");
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("hit", ADDR_W'(exp_r.hit), ADDR_W'(out_hit));
          check_field("writeback_valid", ADDR_W'(exp_r.wb_valid),
                      ADDR_W'(out_writeback_valid));
          check_field("writeback_address", exp_r.wb_addr, out_writeback_address);
          check_field("fill_valid", ADDR_W'(exp_r.fill_valid), ADDR_W'(out_fill_valid));
          check_field("fill_address", exp_r.fill_addr, out_fill_address);
          check_field("access_total", ADDR_W'(exp_r.accesses), ADDR_W'(out_access_total));
          check_field("miss_total", ADDR_W'(exp_r.misses), ADDR_W'(out_miss_total));
          check_field("writeback_total", ADDR_W'(exp_r.writebacks),
                      ADDR_W'(out_writeback_total));
        end
      end
      if (start && !busy) begin
        predict_access(in_kind == KIND_WRITE, in_address, new_r);
        expected_results.push_back(new_r);
      end
    end
    pending = expected_results.size();
  end

endmodule

/* tb/set_assoc_cache_lru_writeback_tb.sv */
`timescale 1ns / 1ps

module set_assoc_cache_lru_writeback_tb;
  import sacl_pkg::*;
  import sacl_tb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ITEMS_PER_PHASE = 92;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_kind;
  logic [ADDR_W-1:0] in_address;
  logic              out_valid;
  logic              out_hit;
  logic              out_writeback_valid;
  logic [ADDR_W-1:0] out_writeback_address;
  logic              out_fill_valid;
  logic [ADDR_W-1:0] out_fill_address;
  logic [CNT_W-1:0]  out_access_total;
  logic [CNT_W-1:0]  out_miss_total;
  logic [CNT_W-1:0]  out_writeback_total;
  logic              cfg_we;
  logic              cfg_index;
  logic              cfg_data;
  int                mismatches;
  int                pending;
  int                cycle_count = 0;
  bit                no_gaps = 0;

  set_assoc_cache_lru_writeback dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_kind               (in_kind),
    .in_address            (in_address),
    .out_valid             (out_valid),
    .out_hit               (out_hit),
    .out_writeback_valid   (out_writeback_valid),
    .out_writeback_address (out_writeback_address),
    .out_fill_valid        (out_fill_valid),
    .out_fill_address      (out_fill_address),
    .out_access_total      (out_access_total),
    .out_miss_total        (out_miss_total),
    .out_writeback_total   (out_writeback_total),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  sacl_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_kind               (in_kind),
    .in_address            (in_address),
    .out_valid             (out_valid),
    .out_hit               (out_hit),
    .out_writeback_valid   (out_writeback_valid),
    .out_writeback_address (out_writeback_address),
    .out_fill_valid        (out_fill_valid),
    .out_fill_address      (out_fill_address),
    .out_access_total      (out_access_total),
    .out_miss_total        (out_miss_total),
    .out_writeback_total   (out_writeback_total),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .mismatches            (mismatches),
    .pending               (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] make_addr(tag_t t, set_t s, logic [OFS_BITS-1:0] o);
    return {t, s, o};
  endfunction

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_request(input logic kind, input logic [ADDR_W-1:0] addr);
    int gap;
    if ($urandom_range(0, 24) == 0) no_gaps = !no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_address <= addr;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_config(input logic policy, input logic lower_present);
    cfg_we <= 1'b1;
    cfg_index <= REG_POLICY;
    cfg_data <= policy;
    @(negedge clk);
    cfg_index <= REG_LOWER_LEVEL;
    cfg_data <= lower_present;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Most requests reuse a handful of tags in a few sets, so hits, evictions and
  // dirty writebacks are frequent; the rest are fully random addresses.
  task automatic run_random_phase(input logic policy, input logic lower_present);
    tag_t              tag_pool[6];
    set_t              set_pool[3];
    logic [ADDR_W-1:0] addr;
    drain();
    set_config(policy, lower_present);
    for (int i = 0; i < 6; i++) tag_pool[i] = TAG_W'({$urandom(), $urandom()});
    for (int i = 0; i < 3; i++) set_pool[i] = SET_AW'($urandom());
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      if ($urandom_range(0, 99) < 85)
        addr = make_addr(tag_pool[$urandom_range(0, 5)], set_pool[$urandom_range(0, 2)],
                         OFS_BITS'($urandom()));
      else
        addr = ADDR_W'({$urandom(), $urandom()});
      send_request(logic'($urandom_range(0, 1)), addr);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = KIND_READ;
    in_address = '0;
    cfg_we = 1'b0;
    cfg_index = REG_POLICY;
    cfg_data = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_config(POLICY_OLDEST, 1'b1);
    send_request(KIND_READ, '0);
    send_request(KIND_READ, '0);
    send_request(KIND_WRITE, make_addr('0, '0, '1));
    send_request(KIND_WRITE, '1);
    send_request(KIND_READ, make_addr(tag_t'(1), '0, '0));
    send_request(KIND_READ, make_addr(tag_t'(2), '0, OFS_BITS'(5)));
    send_request(KIND_READ, make_addr(tag_t'(3), '0, OFS_BITS'(9)));
    // Set 0 is full: the oldest line is the dirty one at tag 0.
    send_request(KIND_READ, make_addr(tag_t'(4), '0, '0));
    send_request(KIND_READ, '0);
    send_request(KIND_READ, '1);

    // Without a lower level, the dirty all-ones line is evicted silently.
    drain();
    set_config(POLICY_OLDEST, 1'b0);
    for (int t = 5; t < 9; t++) send_request(KIND_WRITE, make_addr(tag_t'(t), '1, '0));

    drain();
    set_config(POLICY_RANDOM, 1'b1);
    for (int t = 9; t < 14; t++)
      send_request(KIND_WRITE, make_addr(tag_t'(t), '0, OFS_BITS'(t)));

    run_random_phase(POLICY_OLDEST, 1'b1);
    run_random_phase(POLICY_RANDOM, 1'b1);
    run_random_phase(POLICY_OLDEST, 1'b0);
    run_random_phase(POLICY_RANDOM, 1'b0);
    run_random_phase(POLICY_RANDOM, 1'b1);
    run_random_phase(POLICY_OLDEST, 1'b1);

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
